[rtl/core/sha1ns_pkg.sv]
// Shared constants, types and functions for the SHA-1 nonce search block.
`timescale 1ns / 1ps
package sha1ns_pkg;

  localparam int NumRounds  = 80;
  localparam int NumNonces  = 95;
  localparam logic [6:0] NonceFirst = 7'd32;
  localparam logic [6:0] NonceLast  = 7'd126;
  localparam logic [6:0] CoinCap    = 7'd99;

  localparam logic [2:0] CFG_SALT0  = 3'd0;
  localparam logic [2:0] CFG_SALT1  = 3'd1;
  localparam logic [2:0] CFG_SALT2  = 3'd2;
  localparam logic [2:0] CFG_SALT3  = 3'd3;
  localparam logic [2:0] CFG_SALT4  = 3'd4;
  localparam logic [2:0] CFG_TARGET = 3'd5;

  localparam logic [63:0] LcgMul = 64'd6364136223846793005;
  localparam logic [63:0] LcgAdd = 64'd1442695040888963407;
  localparam logic [31:0] TargetReset = 32'hAAD20250;

  localparam logic [31:0] Hdr0 = 32'h44455449;
  localparam logic [31:0] Hdr1 = 32'h20636F69;
  localparam logic [31:0] Hdr2 = 32'h6E203220;

  localparam logic [31:0] Iv0 = 32'h67452301;
  localparam logic [31:0] Iv1 = 32'hEFCDAB89;
  localparam logic [31:0] Iv2 = 32'h98BADCFE;
  localparam logic [31:0] Iv3 = 32'h10325476;
  localparam logic [31:0] Iv4 = 32'hC3D2E1F0;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
  } sha_state_t;

  // Tag that travels with each hash through the round chain.
  typedef struct packed {
    logic       vld;
    logic       first;
    logic       last;
    logic [6:0] nonce;
  } sha_tag_t;

  function automatic logic [7:0] printable(input logic [7:0] b);
    logic [14:0] p;
    p = {7'd0, b} * 15'd95;
    return 8'h20 + {1'b0, p[14:8]};
  endfunction

endpackage

[rtl/core/sha1ns_round.sv]
// One SHA-1 round cell: applies one round and advances the message window.
`timescale 1ns / 1ps
module sha1ns_round
  import sha1ns_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [6:0]        round_idx,
  input  sha_tag_t          tag_in,
  input  sha_state_t        st_in,
  input  logic [511:0]      w_in,
  output sha_tag_t          tag_out,
  output sha_state_t        st_out,
  output logic [511:0]      w_out
);

  sha_tag_t     tag_r;
  sha_state_t   st_r, st_nxt;
  logic [511:0] w_r, w_nxt;
  logic [31:0]  f, k, t, wn, wx;

  always_comb begin
    if (round_idx < 7'd20) begin
      f = (st_in.b & st_in.c) | (~st_in.b & st_in.d);
      k = 32'h5A827999;
    end else if (round_idx < 7'd40) begin
      f = st_in.b ^ st_in.c ^ st_in.d;
      k = 32'h6ED9EBA1;
    end else if (round_idx < 7'd60) begin
      f = (st_in.b & st_in.c) | (st_in.b & st_in.d) | (st_in.c & st_in.d);
      k = 32'h8F1BBCDC;
    end else begin
      f = st_in.b ^ st_in.c ^ st_in.d;
      k = 32'hCA62C1D6;
    end
    // w window: word j of the window at bits [511-32j -: 32]
    t = {st_in.a[26:0], st_in.a[31:27]} + f + st_in.e + k + w_in[511:480];
    st_nxt.a = t;
    st_nxt.b = st_in.a;
    st_nxt.c = {st_in.b[1:0], st_in.b[31:2]};
    st_nxt.d = st_in.c;
    st_nxt.e = st_in.d;
    wx = w_in[511-32*13 -: 32] ^ w_in[511-32*8 -: 32] ^ w_in[511-32*2 -: 32]
       ^ w_in[511:480];
    wn = {wx[30:0], wx[31]};
    w_nxt = {w_in[479:0], wn};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else begin
      tag_r <= tag_in;
    end
    st_r <= st_nxt;
    w_r  <= w_nxt;
  end

  assign tag_out = tag_r;
  assign st_out  = st_r;
  assign w_out   = w_r;

endmodule

[rtl/core/sha1ns_pick.sv]
// Hit collector: counts matches over one sweep and keeps the lowest hit.
`timescale 1ns / 1ps
module sha1ns_pick
  import sha1ns_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] target,
  input  sha_tag_t    tag_in,
  input  sha_state_t  dig_in,
  output logic        done,
  output logic [6:0]  cnt,
  output logic [6:0]  nonce,
  output logic [127:0] best
);

  logic [6:0]   cnt_r, cnt_nxt, nonce_r, nonce_nxt;
  logic [127:0] best_r, best_nxt;
  logic         done_r;
  logic         hit;

  always_comb begin
    hit = tag_in.vld && (dig_in.a == target);
    cnt_nxt   = tag_in.first ? 7'd0 : cnt_r;
    nonce_nxt = tag_in.first ? 7'd0 : nonce_r;
    best_nxt  = tag_in.first ? '0 : best_r;
    if (hit) begin
      if (cnt_nxt == 7'd0) begin
        nonce_nxt = tag_in.nonce;
        best_nxt  = {dig_in.b, dig_in.c, dig_in.d, dig_in.e};
      end
      cnt_nxt = cnt_nxt + 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= tag_in.vld && tag_in.last;
      if (tag_in.vld) cnt_r <= cnt_nxt;
    end
    if (tag_in.vld) begin
      nonce_r <= nonce_nxt;
      best_r  <= best_nxt;
    end
  end

  assign done  = done_r;
  assign cnt   = cnt_r;
  assign nonce = nonce_r;
  assign best  = best_r;

endmodule

[rtl/core/sha1_nonce_search.sv]
// Top level of the SHA-1 nonce search block.
//
// Usage: write the salt and target registers through cfg_we/cfg_index/cfg_wdata
// while idle. Raise start with in_candidate_seed; the request is taken when
// busy is low. The seed passes through a two-stage LCG step, then the block
// issues one nonce (32..126) per cycle into an 80-cell chain of SHA-1 round
// cells; each cell holds one hash in flight and hands it on every cycle.
// A new request waits until the gap counter behind busy has run down; that
// counter is the only limit: sweeps overlap in the chain back to back. A result
// passes the LCG, issue, round, final-add, collector and output registers;
// out_valid is high for one cycle and the receiver cannot stall. Reset clears
// the control state and reloads the register defaults (target 0xAAD20250,
// salts 0). Outputs are zero when no nonce hit the target.
`timescale 1ns / 1ps
module sha1_nonce_search
  import sha1ns_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_candidate_seed,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  output logic        out_valid,
  output logic        out_hit_found,
  output logic [6:0]  out_hit_count,
  output logic [6:0]  out_hit_nonce,
  output logic [31:0] out_digest_word_1,
  output logic [31:0] out_digest_word_2,
  output logic [31:0] out_digest_word_3,
  output logic [31:0] out_digest_word_4,
  output logic [6:0]  out_coin_value
);

  logic [63:0] salt0_r, salt1_r, salt2_r, salt3_r;
  logic [15:0] salt4_r;
  logic [31:0] target_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      salt0_r <= '0; salt1_r <= '0; salt2_r <= '0; salt3_r <= '0;
      salt4_r <= '0; target_r <= TargetReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SALT0:  salt0_r  <= cfg_wdata;
        CFG_SALT1:  salt1_r  <= cfg_wdata;
        CFG_SALT2:  salt2_r  <= cfg_wdata;
        CFG_SALT3:  salt3_r  <= cfg_wdata;
        CFG_SALT4:  salt4_r  <= cfg_wdata[15:0];
        CFG_TARGET: target_r <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  // LCG: split 64x64 low product into 32-bit partial products over two stages.
  logic        s1_vld_r, s2_vld_r;
  logic [63:0] pll_r, seed_lo_nxt;
  logic [31:0] pcross_r;
  logic [63:0] r_r;
  logic        accept;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= accept;
      s2_vld_r <= s1_vld_r;
    end
    pll_r    <= {32'd0, in_candidate_seed[31:0]} * {32'd0, LcgMul[31:0]};
    pcross_r <= in_candidate_seed[31:0] * LcgMul[63:32]
              + in_candidate_seed[63:32] * LcgMul[31:0];
    r_r      <= pll_r + {pcross_r, 32'd0} + LcgAdd;
  end
  assign seed_lo_nxt = r_r;

  // Issue counter: hold the message words and step one nonce per cycle.
  logic [31:0] m11_r, m12_r, m13_r;
  logic [6:0]  issue_r, issue_nxt;
  logic        run_r, run_nxt;
  logic [6:0]  gap_r, gap_nxt;

  always_comb begin
    run_nxt   = run_r;
    issue_nxt = issue_r;
    if (s2_vld_r) begin
      run_nxt   = 1'b1;
      issue_nxt = NonceFirst;
    end else if (run_r) begin
      if (issue_r == NonceLast) run_nxt = 1'b0;
      else issue_nxt = issue_r + 7'd1;
    end
    // gap counts down cycles until the next request may enter
    gap_nxt = accept ? 7'(NumNonces - 1) : (gap_r != 7'd0 ? gap_r - 7'd1 : 7'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r   <= 1'b0;
      issue_r <= NonceFirst;
      gap_r   <= '0;
    end else begin
      run_r   <= run_nxt;
      issue_r <= issue_nxt;
      gap_r   <= gap_nxt;
    end
    if (s2_vld_r) begin
      m11_r <= {salt4_r, printable(seed_lo_nxt[7:0]), printable(seed_lo_nxt[15:8])};
      m12_r <= {printable(seed_lo_nxt[23:16]), printable(seed_lo_nxt[31:24]),
                printable(seed_lo_nxt[39:32]), printable(seed_lo_nxt[47:40])};
      m13_r <= {printable(seed_lo_nxt[55:48]), 8'd0, 8'h0A, 8'h80};
    end
  end

  assign busy = (gap_r != 7'd0);

  // Round chain.
  sha_tag_t     tag_c [NumRounds+1];
  sha_state_t   st_c  [NumRounds+1];
  logic [511:0] w_c   [NumRounds+1];

  assign tag_c[0].vld   = run_r;
  assign tag_c[0].first = (issue_r == NonceFirst);
  assign tag_c[0].last  = (issue_r == NonceLast);
  assign tag_c[0].nonce = issue_r;
  assign st_c[0]        = '{a: Iv0, b: Iv1, c: Iv2, d: Iv3, e: Iv4};
  assign w_c[0] = {Hdr0, Hdr1, Hdr2, salt0_r, salt1_r, salt2_r, salt3_r, m11_r, m12_r,
                   m13_r | {9'd0, issue_r, 16'd0}, 32'd0, 32'd440};

  for (genvar g = 0; g < NumRounds; g++) begin : g_round
    sha1ns_round u_round (
      .clk       (clk),
      .rst_n     (rst_n),
      .round_idx (7'(g)),
      .tag_in    (tag_c[g]),
      .st_in     (st_c[g]),
      .w_in      (w_c[g]),
      .tag_out   (tag_c[g+1]),
      .st_out    (st_c[g+1]),
      .w_out     (w_c[g+1])
    );
  end

  // Final add of the chaining values.
  sha_tag_t   fin_tag_r;
  sha_state_t dig_r;
  always_ff @(posedge clk) begin
    if (!rst_n) fin_tag_r <= '0;
    else fin_tag_r <= tag_c[NumRounds];
    dig_r.a <= st_c[NumRounds].a + Iv0;
    dig_r.b <= st_c[NumRounds].b + Iv1;
    dig_r.c <= st_c[NumRounds].c + Iv2;
    dig_r.d <= st_c[NumRounds].d + Iv3;
    dig_r.e <= st_c[NumRounds].e + Iv4;
  end

  logic         done;
  logic [6:0]   cnt, nonce;
  logic [127:0] best;

  sha1ns_pick u_pick (
    .clk    (clk),
    .rst_n  (rst_n),
    .target (target_r),
    .tag_in (fin_tag_r),
    .dig_in (dig_r),
    .done   (done),
    .cnt    (cnt),
    .nonce  (nonce),
    .best   (best)
  );

  // Leading zeros over 128 bits: count per 32-bit word, then combine.
  logic [5:0] lz [4];
  logic [7:0] lz_sum;
  logic [6:0] coin;
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      lz[i] = 6'd32;
      for (int j = 0; j < 32; j++) begin
        if (best[127-32*i-31+j]) lz[i] = 6'(31 - j);
      end
    end
    if (lz[0] != 6'd32) lz_sum = {2'd0, lz[0]};
    else if (lz[1] != 6'd32) lz_sum = 8'd32 + {2'd0, lz[1]};
    else if (lz[2] != 6'd32) lz_sum = 8'd64 + {2'd0, lz[2]};
    else lz_sum = 8'd96 + {2'd0, lz[3]};
    coin = (lz_sum > {1'b0, CoinCap}) ? CoinCap : lz_sum[6:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else out_valid <= done;
    out_hit_found     <= (cnt != 7'd0);
    out_hit_count     <= cnt;
    out_hit_nonce     <= nonce;
    out_digest_word_1 <= best[127:96];
    out_digest_word_2 <= best[95:64];
    out_digest_word_3 <= best[63:32];
    out_digest_word_4 <= best[31:0];
    out_coin_value    <= (cnt != 7'd0) ? coin : 7'd0;
  end

endmodule

[sim/tb_sha1_nonce_search.sv]
// Self-checking testbench for the SHA-1 nonce search block.
`timescale 1ns / 1ps
module tb_sha1_nonce_search;
  import sha1ns_pkg::*;

  // Unused register slots: writes there must leave every register untouched.
  localparam logic [2:0] CfgSpare6 = 3'd6;
  localparam logic [2:0] CfgSpare7 = 3'd7;
  localparam int DrainCycles = 200;   // more than the accept-to-result latency
  localparam int WatchLimit  = 6000;  // longest quiet stretch plus margin
  localparam int NumPhases   = 10;
  localparam int PhaseItems  = 45;

  typedef struct packed {
    logic        hit_found;
    logic [6:0]  hit_count;
    logic [6:0]  hit_nonce;
    logic [31:0] dw1;
    logic [31:0] dw2;
    logic [31:0] dw3;
    logic [31:0] dw4;
    logic [6:0]  coin;
  } sweep_t;

  typedef struct {
    logic [63:0] seed;
    bit          typed;   // expectation typed in: a plain miss
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [63:0] in_candidate_seed;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_wdata;
  logic        out_valid;
  logic        out_hit_found;
  logic [6:0]  out_hit_count;
  logic [6:0]  out_hit_nonce;
  logic [31:0] out_digest_word_1;
  logic [31:0] out_digest_word_2;
  logic [31:0] out_digest_word_3;
  logic [31:0] out_digest_word_4;
  logic [6:0]  out_coin_value;

  sha1_nonce_search u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_candidate_seed(in_candidate_seed),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_hit_found(out_hit_found),
    .out_hit_count(out_hit_count), .out_hit_nonce(out_hit_nonce),
    .out_digest_word_1(out_digest_word_1), .out_digest_word_2(out_digest_word_2),
    .out_digest_word_3(out_digest_word_3), .out_digest_word_4(out_digest_word_4),
    .out_coin_value(out_coin_value)
  );

  // Shadow copy of the register file.
  logic [63:0] salt_w0, salt_w1, salt_w2, salt_w3;
  logic [15:0] salt_tail;
  logic [31:0] target;

  sweep_t sweep_q[$];   // expected sweep results, oldest first
  int     errors;
  int     n_requests;
  int     n_results;
  int     n_hits;
  int     quiet;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [7:0] to_print(input logic [7:0] b);
    logic [15:0] p;
    p = {8'd0, b} * 16'd95;
    return 8'h20 + p[15:8];
  endfunction

  // Message words 0..13 for one seed and one nonce character.
  function automatic logic [447:0] form_message(input logic [63:0] seed,
                                                input logic [7:0] nonce);
    logic [63:0] r;
    r = seed * LcgMul + LcgAdd;
    return {Hdr0, Hdr1, Hdr2, salt_w0, salt_w1, salt_w2, salt_w3, salt_tail,
            to_print(r[7:0]), to_print(r[15:8]), to_print(r[23:16]),
            to_print(r[31:24]), to_print(r[39:32]), to_print(r[47:40]),
            to_print(r[55:48]), nonce, 8'h0A, 8'h80};
  endfunction

  function automatic logic [159:0] sha1_single(input logic [447:0] msg);
    logic [31:0] w[80];
    logic [31:0] a, b, c, d, e, f, k, t, x;
    for (int i = 0; i < 14; i++) w[i] = msg[447 - 32 * i -: 32];
    w[14] = 32'd0;
    w[15] = 32'd440;
    for (int i = 16; i < 80; i++) begin
      x = w[i - 3] ^ w[i - 8] ^ w[i - 14] ^ w[i - 16];
      w[i] = {x[30:0], x[31]};
    end
    a = Iv0; b = Iv1; c = Iv2; d = Iv3; e = Iv4;
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d); k = 32'h5A827999;
      end else if (i < 40) begin
        f = b ^ c ^ d; k = 32'h6ED9EBA1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
      end else begin
        f = b ^ c ^ d; k = 32'hCA62C1D6;
      end
      t = {a[26:0], a[31:27]} + f + e + k + w[i];
      e = d; d = c; c = {b[1:0], b[31:2]}; b = a; a = t;
    end
    return {a + Iv0, b + Iv1, c + Iv2, d + Iv3, e + Iv4};
  endfunction

  // Sweep all 95 nonce characters; report the lowest hit and count all of them.
  function automatic sweep_t predict_sweep(input logic [63:0] seed);
    sweep_t      res;
    logic [159:0] dig;
    logic [127:0] tail;
    int          zeros;
    res = '0;
    for (int c = NonceFirst; c <= NonceLast; c++) begin
      dig = sha1_single(form_message(seed, c[7:0]));
      if (dig[159:128] == target) begin
        if (res.hit_count == 0) begin
          res.hit_found = 1'b1;
          res.hit_nonce = c[6:0];
          {res.dw1, res.dw2, res.dw3, res.dw4} = dig[127:0];
        end
        res.hit_count++;
      end
    end
    if (res.hit_found) begin
      tail = {res.dw1, res.dw2, res.dw3, res.dw4};
      zeros = 0;
      while (zeros < 128 && !tail[127 - zeros]) zeros++;
      res.coin = (zeros > CoinCap) ? CoinCap : zeros[6:0];
    end
    return res;
  endfunction

  // ---------------------------------------------------------------- drivers

  // Call right after a rising edge; the write lands on the next one.
  task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_SALT0:  salt_w0 = val;
      CFG_SALT1:  salt_w1 = val;
      CFG_SALT2:  salt_w2 = val;
      CFG_SALT3:  salt_w3 = val;
      CFG_SALT4:  salt_tail = val[15:0];
      CFG_TARGET: target = val[31:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Mostly short gaps, a few long ones; zero when the phase runs back to back.
  task automatic send_seed(input logic [63:0] seed, input bit typed, input bit tight);
    int gap;
    sweep_t exp_res;
    gap = 0;
    if (!tight)
      gap = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 4) : $urandom_range(20, 300);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start             <= 1'b1;
    in_candidate_seed <= seed;
    do @(posedge clk); while (busy);
    exp_res = typed ? sweep_t'('0) : predict_sweep(seed);
    sweep_q.push_back(exp_res);
    n_requests++;
    if (exp_res.hit_found) n_hits++;
  endtask

  // Hold off until every sweep has come back and the chain has emptied.
  task automatic drain;
    start <= 1'b0;
    while (sweep_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- checker

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    sweep_t e;
    if (rst_n && out_valid) begin
      n_results++;
      if (sweep_q.size() == 0) begin
        $display("%0t: result with no request pending: expected none, actual count %0d",
                 $time, out_hit_count);
        errors++;
      end else begin
        e = sweep_q.pop_front();
        check_field("hit_found", 32'(e.hit_found), 32'(out_hit_found));
        check_field("hit_count", 32'(e.hit_count), 32'(out_hit_count));
        check_field("hit_nonce", 32'(e.hit_nonce), 32'(out_hit_nonce));
        check_field("digest_word_1", e.dw1, out_digest_word_1);
        check_field("digest_word_2", e.dw2, out_digest_word_2);
        check_field("digest_word_3", e.dw3, out_digest_word_3);
        check_field("digest_word_4", e.dw4, out_digest_word_4);
        check_field("coin_value", 32'(e.coin), 32'(out_coin_value));
      end
    end
  end

  // Watchdog: any request or result resets the quiet counter.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet <= 0;
    end else if (quiet >= WatchLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // ---------------------------------------------------------------- stimulus

  dir_row_t dir_rows[8] = '{
    '{64'h0000_0000_0000_0000, 1'b1},
    '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1},
    '{64'h0000_0000_0000_0001, 1'b0},
    '{64'h8000_0000_0000_0000, 1'b0},
    '{64'h5555_5555_5555_5555, 1'b0},
    '{64'hAAAA_AAAA_AAAA_AAAA, 1'b0},
    '{64'h0000_0000_FFFF_FFFF, 1'b0},
    '{64'hFFFF_FFFF_0000_0000, 1'b0}
  };

  initial begin
    logic [63:0]  hit_seed;
    logic [7:0]   hit_char;
    logic [159:0] dig;
    bit           tight;
    errors = 0; n_requests = 0; n_results = 0; n_hits = 0;
    rst_n = 1'b0; start = 1'b0; in_candidate_seed = '0;
    cfg_we = 1'b0; cfg_index = '0; cfg_wdata = '0;
    salt_w0 = '0; salt_w1 = '0; salt_w2 = '0; salt_w3 = '0; salt_tail = '0;
    target = TargetReset;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed sweeps against the reset register values.
    foreach (dir_rows[i]) send_seed(dir_rows[i].seed, dir_rows[i].typed, 1'b0);
    drain();

    for (int ph = 0; ph < NumPhases; ph++) begin
      // Salts: all ones, all zeros, then random; wide data to the narrow registers.
      for (int r = 0; r < 4; r++)
        reg_write(r[2:0], (ph == 0) ? '1 : (ph == 1) ? '0 : {$urandom, $urandom});
      reg_write(CFG_SALT4, (ph == 0) ? '1 : (ph == 1) ? '0 : {$urandom, $urandom});
      if (ph == 0) begin
        reg_write(CfgSpare6, {$urandom, $urandom});
        reg_write(CfgSpare7, '1);
      end

      // Except in phases 1 and 2, aim the target at one nonce of a chosen seed for hits.
      hit_seed = {$urandom, $urandom};
      case (ph % 3)
        0: hit_char = 8'(NonceFirst);
        1: hit_char = 8'(NonceLast);
        default: hit_char = 8'($urandom_range(NonceFirst, NonceLast));
      endcase
      dig = sha1_single(form_message(hit_seed, hit_char));
      if (ph == 1) reg_write(CFG_TARGET, 64'd0);
      else if (ph == 2) reg_write(CFG_TARGET, 64'hFFFF_FFFF);
      else reg_write(CFG_TARGET, {$urandom, dig[159:128]});
      cfg_we <= 1'b0;

      tight = (ph % 4 == 3);
      for (int n = 0; n < PhaseItems; n++) begin
        if ($urandom_range(0, 3) == 0) send_seed(hit_seed, 1'b0, tight);
        else send_seed({$urandom, $urandom}, 1'b0, tight);
      end
      drain();
    end

    $display("Covered %0d sweep requests in %0d register phases, %0d results checked,",
             n_requests, NumPhases + 1, n_results);
    $display("%0d of them with a target hit, salt and target extremes included.", n_hits);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
